### rtl/noodet_pkg.sv
`default_nettype none

package noodet_pkg;

  localparam int NOTE_COUNT_DEF = 128;

  localparam int STEP_W = 32;
  localparam int NOTE_W = 7;
  localparam int LVL_W  = 7;
  localparam int KIND_W = 2;
  localparam int MRG_W  = 8;

  // in: step, note, level -> 46 bits padded to 48
  localparam int IN_DATA_W  = 48;
  // out: step, note, velocity -> 46 bits padded to 48
  localparam int OUT_DATA_W = 48;

  localparam logic [LVL_W-1:0] ON_LEVEL     = LVL_W'(8);
  localparam logic [LVL_W-1:0] OFF_VELOCITY = LVL_W'(64);
  localparam logic [MRG_W-1:0] MARGIN_RST   = MRG_W'(128);

  typedef enum logic [KIND_W-1:0] {
    KIND_OFF   = 2'd0,
    KIND_ON    = 2'd1,
    KIND_RAISE = 2'd2
  } event_kind_t;

  // one table entry
  typedef struct packed {
    logic             active;
    logic [LVL_W-1:0] held;
  } note_ent_t;

endpackage

`default_nettype wire

### rtl/note_on_off_detector_core.sv
`default_nettype none

// Channel   Dir  Ports                         Word
// in        in   in_tvalid/in_tready/in_tdata  frame step, note, level
// out       out  out_tvalid/out_tready/...     one event, tlast on the final one
// cfg       in   cfg_valid/cfg_ready/cfg_data  retrigger margin
//
// One item per cycle while the output is free; an item that causes note off then on
// holds the lookup stage until both of its events are on the output register.
// The note table is one synchronous RAM read at accept and written when the
// item leaves the lookup stage; a same-entry write at that edge is bypassed.
// Reset clears a valid bit per entry; an entry not valid reads as off, zero.
// A stalled output holds the lookup stage when the item has an event, and drops in_tready.
module note_on_off_detector_core #(
  parameter int NOTE_COUNT = noodet_pkg::NOTE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] frame_step, [38:32] note_number, [45:39] level, [47:46] zero
  input  wire logic [noodet_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] event_step, [38:32] event_note, [45:39] velocity, [47:46] zero
  output logic [noodet_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [1:0] event_kind
  output logic [noodet_pkg::KIND_W-1:0]          out_tuser,
  // last_event
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [noodet_pkg::MRG_W-1:0]      cfg_data
);

  localparam int AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int STEP_W = noodet_pkg::STEP_W;
  localparam int NOTE_W = noodet_pkg::NOTE_W;
  localparam int LVL_W  = noodet_pkg::LVL_W;
  localparam int MRG_W  = noodet_pkg::MRG_W;

  // config
  logic [MRG_W-1:0] margin_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= noodet_pkg::MARGIN_RST;
    end else if (cfg_valid) begin
      margin_r <= cfg_data;
    end
  end

  // input word
  logic [STEP_W-1:0] in_step;
  logic [NOTE_W-1:0] in_note;
  logic [LVL_W-1:0]  in_lvl;
  logic [AW-1:0]     in_addr;
  logic              in_range;
  logic              acc;

  assign in_step  = in_tdata[STEP_W-1:0];
  assign in_note  = in_tdata[STEP_W+NOTE_W-1:STEP_W];
  assign in_lvl   = in_tdata[STEP_W+NOTE_W+LVL_W-1:STEP_W+NOTE_W];
  assign in_addr  = AW'(in_note);
  assign in_range = (32'(in_note) < NOTE_COUNT);
  assign acc      = in_tvalid && in_tready;

  // table
  noodet_pkg::note_ent_t mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] vld_r;
  noodet_pkg::note_ent_t mem_rd_r;
  logic                  vld_rd_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  noodet_pkg::note_ent_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc && in_range) begin
      mem_rd_r <= mem[in_addr];
      vld_rd_r <= vld_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // lookup stage
  logic                  s1_vld_r;
  logic                  s1_range_r;
  logic [AW-1:0]         s1_addr_r;
  logic [STEP_W-1:0]     s1_step_r;
  logic [NOTE_W-1:0]     s1_note_r;
  logic [LVL_W-1:0]      s1_lvl_r;
  logic                  s1_byp_r;
  noodet_pkg::note_ent_t s1_byp_data_r;
  logic                  s1_ph_r;
  logic                  s1_ph_nxt;

  noodet_pkg::note_ent_t ent;
  logic [LVL_W+1:0]      thr;
  logic [1:0]            nev;
  logic                  upd;
  noodet_pkg::note_ent_t ent_new;
  logic                  out_free;
  logic                  s1_done;
  logic                  ld;

  always_comb begin
    if (s1_byp_r) begin
      ent = s1_byp_data_r;
    end else if (vld_rd_r) begin
      ent = mem_rd_r;
    end else begin
      ent = '0;
    end
    thr = {2'b00, ent.held} + {1'b0, margin_r};
    nev = 2'd0;
    upd = 1'b0;
    ent_new = ent;
    if (s1_range_r) begin
      if (!ent.active) begin
        if (s1_lvl_r > noodet_pkg::ON_LEVEL) begin
          nev = 2'd1;
          upd = 1'b1;
          ent_new.active = 1'b1;
          ent_new.held = s1_lvl_r;
        end
      end else if (s1_lvl_r == '0) begin
        nev = 2'd1;
        upd = 1'b1;
        ent_new.active = 1'b0;
      end else if ({2'b00, s1_lvl_r} >= thr) begin
        nev = 2'd2;
        upd = 1'b1;
        ent_new.held = s1_lvl_r;
      end else if (s1_lvl_r > ent.held) begin
        nev = 2'd1;
        upd = 1'b1;
        ent_new.held = s1_lvl_r;
      end
    end
  end

  assign out_free = !out_tvalid || out_tready;
  assign ld       = s1_vld_r && (nev != 2'd0) && out_free;
  assign s1_done  = s1_vld_r && ((nev == 2'd0) ||
                    (out_free && ((nev == 2'd1) || s1_ph_r)));
  assign in_tready = !s1_vld_r || s1_done;

  assign wr_en   = s1_done && upd;
  assign wr_addr = s1_addr_r;
  assign wr_data = ent_new;

  always_comb begin
    s1_ph_nxt = s1_ph_r;
    if (s1_done) begin
      s1_ph_nxt = 1'b0;
    end else if (ld) begin
      s1_ph_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_ph_r  <= 1'b0;
    end else begin
      s1_ph_r <= s1_ph_nxt;
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_done) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_range_r    <= in_range;
      s1_addr_r     <= in_addr;
      s1_step_r     <= in_step;
      s1_note_r     <= in_note;
      s1_lvl_r      <= in_lvl;
      // entry written at the same edge it is read: RAM gives old data
      s1_byp_r      <= wr_en && (wr_addr == in_addr);
      s1_byp_data_r <= wr_data;
    end
  end

  // output register
  logic                    out_vld_r;
  logic [STEP_W-1:0]       out_step_r;
  logic [NOTE_W-1:0]       out_note_r;
  logic [LVL_W-1:0]        out_vel_r;
  noodet_pkg::event_kind_t out_kind_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_step_r <= s1_step_r;
      out_note_r <= s1_note_r;
      if ((nev == 2'd2) && !s1_ph_r) begin
        out_kind_r <= noodet_pkg::KIND_OFF;
        out_vel_r  <= noodet_pkg::OFF_VELOCITY;
        out_last_r <= 1'b0;
      end else if ((nev == 2'd2) || !ent.active) begin
        out_kind_r <= noodet_pkg::KIND_ON;
        out_vel_r  <= s1_lvl_r;
        out_last_r <= 1'b1;
      end else if (s1_lvl_r == '0) begin
        out_kind_r <= noodet_pkg::KIND_OFF;
        out_vel_r  <= noodet_pkg::OFF_VELOCITY;
        out_last_r <= 1'b1;
      end else begin
        out_kind_r <= noodet_pkg::KIND_RAISE;
        out_vel_r  <= s1_lvl_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_vel_r, out_note_r, out_step_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### sim/note_on_off_checker.sv
`timescale 1ns / 100ps

// Watches the note, event and margin channels. It keeps its own note table,
// predicts the event words of every accepted note word and compares them in
// order.
module note_on_off_checker
  import noodet_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic [KIND_W-1:0]     out_tuser,
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [MRG_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         words_checked
);

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [NOTE_W-1:0] note;
    event_kind_t       kind;
    logic [LVL_W-1:0]  vel;
    logic              last;
  } note_event_t;

  logic             note_on  [NOTE_COUNT_DEF];
  logic [LVL_W-1:0] held_vel [NOTE_COUNT_DEF];
  logic [MRG_W-1:0] margin;
  note_event_t      due_events[$];

  task automatic push_event(input logic [STEP_W-1:0] step, input logic [NOTE_W-1:0] note,
                            input event_kind_t kind, input logic [LVL_W-1:0] vel,
                            input logic last);
    note_event_t ev;
    ev.step = step;
    ev.note = note;
    ev.kind = kind;
    ev.vel  = vel;
    ev.last = last;
    due_events.push_back(ev);
  endtask

  task automatic apply_level(input logic [STEP_W-1:0] step, input logic [NOTE_W-1:0] note,
                             input logic [LVL_W-1:0] lvl);
    if (!note_on[note]) begin
      if (lvl > ON_LEVEL) begin
        note_on[note]  = 1'b1;
        held_vel[note] = lvl;
        push_event(step, note, KIND_ON, lvl, 1'b1);
      end
    end else if (lvl == '0) begin
      // held velocity stays as it was
      note_on[note] = 1'b0;
      push_event(step, note, KIND_OFF, OFF_VELOCITY, 1'b1);
    end else if (int'(lvl) >= int'(held_vel[note]) + int'(margin)) begin
      // sum taken wide: a margin above 127 never retriggers
      held_vel[note] = lvl;
      push_event(step, note, KIND_OFF, OFF_VELOCITY, 1'b0);
      push_event(step, note, KIND_ON, lvl, 1'b1);
    end else if (lvl > held_vel[note]) begin
      held_vel[note] = lvl;
      push_event(step, note, KIND_RAISE, lvl, 1'b1);
    end
  endtask

  function automatic bit same_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_word();
    note_event_t want;
    note_event_t got;
    got.step = out_tdata[31:0];
    got.note = out_tdata[38:32];
    got.vel  = out_tdata[45:39];
    got.kind = event_kind_t'(out_tuser);
    got.last = out_tlast;
    words_checked++;
    if (due_events.size() == 0) begin
      $display("%0t: event word with none expected, actual step %0d note %0d kind %0d vel %0d",
               $time, got.step, got.note, got.kind, got.vel);
      fail_count++;
    end else begin
      want = due_events.pop_front();
      if (!(same_field("event_step", want.step, got.step) &
            same_field("event_note", want.note, got.note) &
            same_field("event_kind", want.kind, got.kind) &
            same_field("velocity", want.vel, got.vel) &
            same_field("last_event", want.last, got.last)))
        fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_COUNT_DEF; i++) begin
        note_on[i]  = 1'b0;
        held_vel[i] = '0;
      end
      margin = MARGIN_RST;
      due_events.delete();
      fail_count    = 0;
      words_checked = 0;
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready)
        check_word();
      if (in_tvalid && in_tready)
        apply_level(in_tdata[31:0], in_tdata[38:32], in_tdata[45:39]);
      if (cfg_valid && cfg_ready)
        margin = cfg_data;
      pending <= due_events.size();
    end
  end

endmodule

### sim/tb_note_on_off_detector_core.sv
`timescale 1ns / 100ps

module tb_note_on_off_detector_core;
  import noodet_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 82;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 150;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [MRG_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_ready;

  int                    fail_count;
  int                    pending;
  int                    words_checked;
  int                    items_sent    = 0;
  int                    margin_writes = 0;
  bit                    in_burst      = 1'b0;
  bit                    out_burst     = 1'b0;
  logic [STEP_W-1:0]     frame_step    = '0;
  logic [NOTE_W-1:0]     note_pool [6];

  note_on_off_detector_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  note_on_off_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL note_on_off_detector_core");
    $finish;
  end

  // Event receiver; two long holds let the block fill up and stall its input.
  initial begin : receiver
    int words_rx;
    int hold;
    words_rx = 0;
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 5);
      if (words_rx == 60 || words_rx == 240) hold = LONG_HOLD;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      words_rx++;
    end
  end

  task automatic send_level(input logic [STEP_W-1:0] step, input logic [NOTE_W-1:0] note,
                            input logic [LVL_W-1:0] lvl);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, lvl, note, step};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Waits out every expected event, then the pipeline for words with no event.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_margin(input logic [MRG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    margin_writes++;
  endtask

  // Mostly a handful of notes per phase so they go on, rise, retrigger and off.
  task automatic send_random_level();
    int                roll;
    logic [NOTE_W-1:0] note;
    logic [LVL_W-1:0]  lvl;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      frame_step = $urandom();
    else if (roll < 30)
      frame_step = frame_step + $urandom_range(1, 512);
    if ($urandom_range(0, 9) < 7)
      note = note_pool[$urandom_range(0, 5)];
    else
      note = NOTE_W'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 15)
      lvl = '0;
    else if (roll < 25)
      lvl = LVL_W'($urandom_range(1, 8));
    else
      lvl = LVL_W'($urandom_range(9, 127));
    send_level(frame_step, note, lvl);
  endtask

  initial begin : stimulus
    logic [MRG_W-1:0] phase_margin;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // margin at reset value: out of reach
    send_level(32'd0, 7'd0, 7'd0);
    send_level(32'd0, 7'd0, 7'd8);
    send_level(32'd1, 7'd0, 7'd9);
    send_level(32'd1, 7'd0, 7'd9);
    send_level(32'd2, 7'd0, 7'd127);
    send_level(32'd3, 7'd0, 7'd5);
    send_level(32'd4, 7'd0, 7'd0);
    send_level(32'hFFFF_FFFF, 7'd127, 7'd127);
    send_level(32'hFFFF_FFFF, 7'd127, 7'd0);
    send_level(32'd5, 7'd0, 7'd127);

    // zero margin: any level at or above held retriggers
    write_margin(8'd0);
    send_level(32'd6, 7'd0, 7'd127);
    send_level(32'd6, 7'd0, 7'd50);
    send_level(32'd7, 7'd42, 7'd20);
    send_level(32'd8, 7'd42, 7'd20);

    write_margin(8'd255);
    send_level(32'd9, 7'd42, 7'd127);
    send_level(32'd10, 7'd42, 7'd0);

    write_margin(8'd10);
    send_level(32'd11, 7'd85, 7'd30);
    send_level(32'd12, 7'd85, 7'd39);
    send_level(32'd13, 7'd85, 7'd49);
    send_level(32'd14, 7'd85, 7'd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_margin = MARGIN_RST;
        1:       phase_margin = 8'd0;
        2:       phase_margin = 8'd255;
        3:       phase_margin = 8'd1;
        4:       phase_margin = 8'd127;
        default: phase_margin = MRG_W'($urandom_range(2, 60));
      endcase
      write_margin(phase_margin);
      for (int k = 0; k < 6; k++)
        note_pool[k] = NOTE_W'($urandom_range(0, 127));
      repeat (PHASE_ITEMS) send_random_level();
    end

    wait_idle();
    $display("run covered %0d note words over %0d margin settings, %0d event words checked",
             items_sent, margin_writes, words_checked);
    if (fail_count == 0 && pending == 0)
      $display("PASS note_on_off_detector_core");
    else
      $display("FAIL note_on_off_detector_core");
    $finish;
  end

endmodule
